### rtl/pcc_pkg.sv
// Shared types and constants of the parallel camera capture block.
package pcc_pkg;

	// One sample of the camera pins and the data port
	typedef struct packed {
		logic        start_req;
		logic        vsync;
		logic        href;
		logic        pclk;
		logic [15:0] port_bits;
	} sample_t;

	// One captured byte
	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       last;
	} result_t;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES   = 8'd3;

	// Register reset values
	localparam int RESET_WIDTH  = 320;
	localparam int RESET_HEIGHT = 240;

	// Result queue: room for two pending items of two bytes each
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// Port word to byte: bits 15..8, with port bit3 ORed into bit0 and bit2 ORed into bit1
	function automatic logic [7:0] port_to_byte(logic [15:0] port);
		return port[15:8] | {6'b0, port[2], port[3]};
	endfunction

endpackage

### rtl/pcc_if.sv
// Channel interfaces of the parallel camera capture block.

// Pin sample channel
interface pcc_sample_if;
	logic             valid;
	logic             ready;
	pcc_pkg::sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Captured byte channel
interface pcc_result_if;
	logic             valid;
	logic             ready;
	pcc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Register write channel
interface pcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pcc_pkg::CFG_IDX_W-1:0]    index;
	logic [pcc_pkg::CFG_DATA_W-1:0]   wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/parallel_camera_capture_core.sv
// Parallel camera capture core: frame sync tracking, byte capture and result queue.
//
// Usage:
//   sample : one request per clock while ready, carrying the sampled vsync,
//            href and pclk pins, the 16-bit data port and a start_req bit. A
//            start_req while idle arms a frame capture; the core then waits
//            for vsync high and low, and for each row waits for href, taking
//            one byte on every pclk-low phase (two bytes per pixel).
//   result : captured bytes, one request each; last marks the final byte.
//   cfg    : register writes (frame_width, frame_height, gray_mode,
//            swap_bytes), always ready; write only while no capture is active.
// A sample is registered at acceptance and processed from that register once
//   the queue has room; its bytes are then written into the result queue.
// Throughput: one sample per cycle. A sample yields at most two bytes and the
//   result side drains one per cycle while ready, through a four-entry queue; a
//   sample is processed only while the queue holds two entries or fewer.
// Reset: the core returns to idle, the queue empties and the registers take
//   320 x 240 (clamped to the maximum sizes), color, no swapping.
// Stall: when result is held off the queue fills and sample.ready drops;
//   nothing is dropped.
module parallel_camera_capture_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	pcc_sample_if.sink          sample,
	pcc_result_if.source        result,
	pcc_cfg_if.sink             cfg
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int BW = WW + 1;
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (pcc_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: pcc_pkg::RESET_WIDTH;
	localparam int H_RST = (pcc_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
		: pcc_pkg::RESET_HEIGHT;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_VS_HIGH   = 3'd1,
		PH_VS_LOW    = 3'd2,
		PH_HREF_HIGH = 3'd3,
		PH_PCLK_LOW  = 3'd4,
		PH_PCLK_HIGH = 3'd5,
		PH_HREF_LOW  = 3'd6
	} phase_t;

	// Size clamps, applied when the register is written
	function automatic logic [WW-1:0] clamp_w(logic [pcc_pkg::CFG_DATA_W-1:0] v);
		if (v == '0) return WW'(1);
		if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
		return WW'(v);
	endfunction

	function automatic logic [HW-1:0] clamp_h(logic [pcc_pkg::CFG_DATA_W-1:0] v);
		if (v == '0) return HW'(1);
		if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
		return HW'(v);
	endfunction

	logic [WW-1:0]          width_q;
	logic [HW-1:0]          height_q;
	logic                   gray_q;
	logic                   swap_q;

	logic                   valid_s1;
	pcc_pkg::sample_t       item_s1;
	logic                   fire;

	phase_t                 phase_q, phase_nx;
	logic [HW-1:0]          row_q, row_nx;
	logic [BW-1:0]          byte_q, byte_nx;
	logic [7:0]             held_q, held_nx;

	logic [BW-1:0]          row_bytes;
	logic [BW-1:0]          byte_inc;
	logic [HW-1:0]          row_inc;
	logic                   frame_done;
	logic                   cap_en;
	logic [BW-1:0]          cap_j;
	logic [HW-1:0]          cap_row;
	logic                   last_row;
	logic                   fin_even;
	logic                   fin_odd;
	logic [7:0]             cap_byte;
	logic                   swp;

	logic [1:0]             n_res;
	pcc_pkg::result_t       res0, res1;

	pcc_pkg::result_t       fifo_q [pcc_pkg::FIFO_DEPTH];
	logic [pcc_pkg::FIFO_AW-1:0] head_q, tail_q;
	logic [pcc_pkg::FIFO_CW-1:0] cnt_q;
	logic [1:0]             n_push;
	logic                   pop;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
			gray_q   <= 1'b0;
			swap_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pcc_pkg::CFG_FRAME_WIDTH:  width_q  <= clamp_w(cfg.wdata);
				pcc_pkg::CFG_FRAME_HEIGHT: height_q <= clamp_h(cfg.wdata);
				pcc_pkg::CFG_GRAY_MODE:    gray_q   <= cfg.wdata[0];
				pcc_pkg::CFG_SWAP_BYTES:   swap_q   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// Input register
	assign fire         = valid_s1 && (cnt_q <= pcc_pkg::FIFO_CW'(2));
	assign sample.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1 <= sample.data;
		end
	end

	// Counters and row/frame end tests
	assign row_bytes  = {width_q, 1'b0};
	assign byte_inc   = byte_q + BW'(1);
	assign row_inc    = row_q + HW'(1);
	assign frame_done = row_inc >= height_q;

	// Phase walk for one sample; several waits may pass in one sample
	always_comb begin
		phase_nx = phase_q;
		row_nx   = row_q;
		byte_nx  = byte_q;
		cap_en   = 1'b0;
		cap_j    = byte_q;
		cap_row  = row_q;
		unique case (phase_q)
			PH_VS_HIGH: begin
				if (item_s1.vsync) phase_nx = PH_VS_LOW;
			end
			PH_VS_LOW: begin
				if (!item_s1.vsync) begin
					row_nx = '0;
					if (!item_s1.href) begin
						phase_nx = PH_HREF_HIGH;
					end else begin
						byte_nx = '0;
						if (item_s1.pclk) begin
							phase_nx = PH_PCLK_LOW;
						end else begin
							cap_en   = 1'b1;
							cap_j    = '0;
							cap_row  = '0;
							phase_nx = PH_PCLK_HIGH;
						end
					end
				end
			end
			PH_HREF_HIGH: begin
				if (item_s1.href) begin
					byte_nx = '0;
					if (item_s1.pclk) begin
						phase_nx = PH_PCLK_LOW;
					end else begin
						cap_en   = 1'b1;
						cap_j    = '0;
						phase_nx = PH_PCLK_HIGH;
					end
				end
			end
			PH_PCLK_LOW: begin
				if (!item_s1.pclk) begin
					cap_en   = 1'b1;
					phase_nx = PH_PCLK_HIGH;
				end
			end
			PH_PCLK_HIGH: begin
				if (item_s1.pclk) begin
					byte_nx = byte_inc;
					if (byte_inc < row_bytes) begin
						phase_nx = PH_PCLK_LOW;
					end else if (item_s1.href) begin
						phase_nx = PH_HREF_LOW;
					end else if (frame_done) begin
						phase_nx = PH_IDLE;
						row_nx   = '0;
						byte_nx  = '0;
					end else begin
						row_nx   = row_inc;
						phase_nx = PH_HREF_HIGH;
					end
				end
			end
			PH_HREF_LOW: begin
				if (!item_s1.href) begin
					if (frame_done) begin
						phase_nx = PH_IDLE;
						row_nx   = '0;
						byte_nx  = '0;
					end else begin
						row_nx   = row_inc;
						phase_nx = PH_HREF_HIGH;
					end
				end
			end
			default: begin
				// idle and the unused code
				if (item_s1.start_req) begin
					row_nx   = '0;
					byte_nx  = '0;
					phase_nx = item_s1.vsync ? PH_VS_LOW : PH_VS_HIGH;
				end else begin
					phase_nx = PH_IDLE;
				end
			end
		endcase
	end

	// Byte capture and result forming
	assign cap_byte = pcc_pkg::port_to_byte(item_s1.port_bits);
	assign swp      = swap_q && !gray_q;
	assign last_row = ({1'b0, cap_row} + (HW + 1)'(1)) >= {1'b0, height_q};
	assign fin_even = last_row
		&& (({1'b0, cap_j} + (BW + 1)'(2)) >= {1'b0, row_bytes});
	assign fin_odd  = last_row
		&& (({1'b0, cap_j} + (BW + 1)'(1)) >= {1'b0, row_bytes});

	always_comb begin
		n_res   = 2'd0;
		res0    = '{pixel_byte: cap_byte, last: 1'b0};
		res1    = '{pixel_byte: held_q, last: fin_odd};
		held_nx = held_q;
		if (cap_en) begin
			if (!cap_j[0]) begin
				if (gray_q) begin
					res0.last = fin_even;
					n_res     = 2'd1;
				end else if (swp) begin
					held_nx = cap_byte;
				end else begin
					n_res = 2'd1;
				end
			end else if (!gray_q) begin
				if (swp) begin
					n_res = 2'd2;
				end else begin
					res0.last = fin_odd;
					n_res     = 2'd1;
				end
			end
		end
	end

	// Capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			row_q   <= '0;
			byte_q  <= '0;
			held_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_nx;
			row_q   <= row_nx;
			byte_q  <= byte_nx;
			held_q  <= held_nx;
		end
	end

	// Result queue
	assign n_push       = fire ? n_res : 2'd0;
	assign pop          = result.valid && result.ready;
	assign result.valid = cnt_q != '0;
	assign result.data  = fifo_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) head_q <= head_q + pcc_pkg::FIFO_AW'(1);
			tail_q <= tail_q + pcc_pkg::FIFO_AW'(n_push);
			cnt_q  <= cnt_q + pcc_pkg::FIFO_CW'(n_push) - pcc_pkg::FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) fifo_q[tail_q] <= res0;
		if (n_push == 2'd2) fifo_q[tail_q + pcc_pkg::FIFO_AW'(1)] <= res1;
	end

endmodule

### rtl/pcc_checker.sv
// Port-level checks of the parallel camera capture core and their binding.
module pcc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_start,
	input logic             out_valid,
	input logic             out_ready,
	input pcc_pkg::result_t out_data
);

	logic [7:0] starts_q;
	logic       start_acc;
	logic       last_acc;

	assign start_acc = in_valid && in_ready && in_start;
	assign last_acc  = out_valid && out_ready && out_data.last;

	// Starts seen minus frame ends delivered; sticks once saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			starts_q <= '0;
		end else if (starts_q != 8'hFF) begin
			if (start_acc && !last_acc) starts_q <= starts_q + 8'd1;
			else if (!start_acc && last_acc) starts_q <= starts_q - 8'd1;
		end
	end

	// A frame end is only reported for a frame that was requested
	a_last_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> starts_q != 8'd0)
		else $error("frame end without a start request");

	// A held-off result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Queue is empty right after reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

endmodule

bind parallel_camera_capture_core pcc_checker u_pcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.in_start  (sample.data.start_req),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
